>>> design/fdly_pkg.sv
// Shared constants and types of the feedback delay effect unit.
package fdly_pkg;

  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned CH_W       = $clog2(CHANNELS);
  localparam int unsigned MAX_LINE   = 524288;
  localparam int unsigned POS_W      = $clog2(MAX_LINE);
  localparam int unsigned LEN_W      = POS_W + 1;
  localparam int unsigned ADDR_W     = CH_W + POS_W;
  localparam int unsigned DEPTH      = CHANNELS * MAX_LINE;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TDATA_W    = ((CH_W + SAMPLE_W + 7) / 8) * 8;

  localparam int unsigned MUL_W      = 19;
  localparam int unsigned PROD_W     = 2 * MUL_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DELAY_W    = 13;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SPM_W      = 6;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned BLK_W      = 11;

  localparam int unsigned DELAY_MIN  = 10;
  localparam int unsigned DELAY_MAX  = 5000;
  localparam int unsigned DELAY_OFS  = 5;
  localparam int unsigned PCT_MAX    = 100;
  localparam int unsigned SPM_MIN    = 1;
  localparam int unsigned SPM_MAX    = 48;
  localparam int unsigned BLOCK_BIAS = 159;
  localparam int unsigned BLOCK_MUL  = 5;

  // floor(x / 160) = (x * RECIP160) >> RECIP160_SHIFT for x below 2^18.
  localparam int unsigned RECIP160       = 209716;
  localparam int unsigned RECIP160_SHIFT = 25;
  // floor(x / 25) = (x * RECIP25) >> RECIP25_SHIFT for x up to 3200.
  localparam int unsigned RECIP25        = 2622;
  localparam int unsigned RECIP25_SHIFT  = 16;
  // pct * 128 / 100 equals (pct * 32) / 25.
  localparam int unsigned PCT_SHIFT      = 5;

  localparam int unsigned LEN_RESET  = 160;
  localparam int unsigned FB_RESET   = 0;
  localparam int unsigned OG_RESET   = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_MS       = 2'd0,
    CFG_FEEDBACK_PCT   = 2'd1,
    CFG_OUTPUT_PCT     = 2'd2,
    CFG_SAMPLES_PER_MS = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC_PROD,
    ST_CALC_BLOCKS,
    ST_CALC_LEN,
    ST_CALC_FB,
    ST_CALC_OG,
    ST_CALC_DONE,
    ST_READ,
    ST_MIX,
    ST_OUT
  } state_e;

endpackage

>>> design/feedback_delay_effect_unit.sv
// Top level of the feedback delay effect unit: sequencer, state and stream ports.
//
// Feedback echo on up to eight audio channels. Each request on the slave stream
// carries a channel index and a signed 16-bit sample. The unit reads the sample
// stored at that channel's ring position, writes back the stored sample scaled
// by the feedback gain plus the live sample (saturated to 16 bits), and sends
// the new value scaled by the output gain on the master stream, tagged with the
// same channel. Each channel's ring has line_length entries, derived from the
// delay and the samples-per-millisecond setting.
//
// A request is accepted in the idle state, where its memory read starts. The
// feedback multiply, the mix with write-back and output multiply on the one shared
// multiplier, and the result load follow, in the read, mix and output states;
// the next request is taken only once the result is loaded and the unit is idle.
// A configuration write recomputes line length and gains on the same multiplier
// in the CALC states, during which no request is taken. It also empties every ring:
// positions go to zero and a per-channel wrap flag makes unwritten entries read
// as zero, so the delay memory is never swept. Reset behaves the same way and
// loads the default settings (10 ms, 0 % feedback, 100 % output, 32 per ms).
// A result waits in the output register while the receiver stalls. The next
// request is still taken, and once finished it holds until the register is free.
module feedback_delay_effect_unit import fdly_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave stream, tdata: channel [2:0], in_sample [18:3], zeros above.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,
  // Master stream, tdata: out_channel [2:0], out_sample [18:3], zeros above.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(2 ** (SAMPLE_W - 1));

  // Truncating division by 128 of a signed product.
  function automatic logic signed [PROD_W-1:0] div128(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? PROD_W'(127) : '0;
    return (p + bias) >>> 7;
  endfunction

  state_e state_q, state_d;

  // Settings.
  logic [DELAY_W-1:0] delay_q;
  logic [PCT_W-1:0]   fb_pct_q, out_pct_q;
  logic [SPM_W-1:0]   spm_q;
  logic [LEN_W-1:0]   line_len_q;
  logic [GAIN_W-1:0]  fb_q, og_q;

  // Per-channel ring state.
  logic [POS_W-1:0]    pos_q [CHANNELS];
  logic [CHANNELS-1:0] wrapped_q;

  // Request in flight.
  logic [CH_W-1:0]            ch_q;
  logic signed [SAMPLE_W-1:0] live_q;
  logic [POS_W-1:0]           cur_pos_q;
  logic                       hit_q;

  // Output register.
  logic                       out_valid_q;
  logic [CH_W-1:0]            out_ch_q;
  logic [SAMPLE_W-1:0]        out_sample_q;

  logic in_acc, cfg_acc, out_load;
  logic [CH_W-1:0]            in_ch;
  logic signed [SAMPLE_W-1:0] in_sample;

  logic                       mul_en;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]   prod_div;

  logic                       ram_en, ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic [SAMPLE_W-1:0]        ram_rdata;

  logic signed [SAMPLE_W-1:0] stored;
  logic signed [PROD_W-1:0]   mix_sum;
  logic signed [SAMPLE_W-1:0] mixed;
  logic [LEN_W-1:0]           pos_next;
  logic [LEN_W-1:0]           len_calc;
  logic [BLK_W-1:0]           blocks;

  assign in_ch     = s_axis_tdata[CH_W-1:0];
  assign in_sample = $signed(s_axis_tdata[CH_W +: SAMPLE_W]);

  // Configuration takes priority when both arrive in the idle state.
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TDATA_W - CH_W - SAMPLE_W){1'b0}}, out_sample_q, out_ch_q};

  // An entry is only meaningful once its channel has gone around the ring.
  assign stored   = hit_q ? $signed(ram_rdata) : '0;
  assign prod_div = div128(mul_p);
  assign mix_sum  = prod_div + PROD_W'(live_q);
  always_comb begin
    if (mix_sum > SAT_HI) begin
      mixed = SAT_HI[SAMPLE_W-1:0];
    end else if (mix_sum < SAT_LO) begin
      mixed = SAT_LO[SAMPLE_W-1:0];
    end else begin
      mixed = mix_sum[SAMPLE_W-1:0];
    end
  end

  assign pos_next = {1'b0, cur_pos_q} + LEN_W'(1);
  assign blocks   = mul_p[RECIP160_SHIFT +: BLK_W];

  always_comb begin
    if (mul_p > PROD_W'(MAX_LINE)) begin
      len_calc = LEN_W'(MAX_LINE);
    end else if (mul_p == '0) begin
      len_calc = LEN_W'(1);
    end else begin
      len_calc = mul_p[LEN_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          state_d = ST_CALC_PROD;
        end else if (in_acc) begin
          state_d = ST_READ;
        end
      end
      ST_CALC_PROD:   state_d = ST_CALC_BLOCKS;
      ST_CALC_BLOCKS: state_d = ST_CALC_LEN;
      ST_CALC_LEN:    state_d = ST_CALC_FB;
      ST_CALC_FB:     state_d = ST_CALC_OG;
      ST_CALC_OG:     state_d = ST_CALC_DONE;
      ST_CALC_DONE:   state_d = ST_IDLE;
      ST_READ:        state_d = ST_MIX;
      ST_MIX:         state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:        state_d = ST_IDLE;
    endcase
  end

  // Multiplier operands and memory controls per step.
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = {ch_q, cur_pos_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !cfg_acc) begin
          ram_en   = 1'b1;
          ram_addr = {in_ch, pos_q[in_ch]};
        end
      end
      ST_CALC_PROD: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(delay_q - DELAY_W'(DELAY_OFS));
        mul_b  = MUL_W'(spm_q);
      end
      ST_CALC_BLOCKS: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mul_p[MUL_W-2:0] + (MUL_W - 1)'(BLOCK_BIAS));
        mul_b  = MUL_W'(RECIP160);
      end
      ST_CALC_LEN: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(spm_q) * MUL_W'(BLOCK_MUL);
        mul_b  = MUL_W'(blocks);
      end
      ST_CALC_FB: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'({fb_pct_q, {PCT_SHIFT{1'b0}}});
        mul_b  = MUL_W'(RECIP25);
      end
      ST_CALC_OG: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'({out_pct_q, {PCT_SHIFT{1'b0}}});
        mul_b  = MUL_W'(RECIP25);
      end
      ST_CALC_DONE: begin
      end
      ST_READ: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(stored);
        mul_b  = MUL_W'(fb_q);
      end
      ST_MIX: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mixed);
        mul_b  = MUL_W'(og_q);
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  fdly_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  fdly_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (mixed),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      delay_q     <= DELAY_W'(DELAY_MIN);
      fb_pct_q    <= '0;
      out_pct_q   <= PCT_W'(PCT_MAX);
      spm_q       <= SPM_W'(32);
      line_len_q  <= LEN_W'(LEN_RESET);
      fb_q        <= GAIN_W'(FB_RESET);
      og_q        <= GAIN_W'(OG_RESET);
      pos_q       <= '{default: '0};
      wrapped_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_acc) begin
        // Every write empties the rings; the settings below then recompute.
        pos_q     <= '{default: '0};
        wrapped_q <= '0;
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_DELAY_MS: begin
            if (cfg_data_i[DELAY_W-1:0] < DELAY_W'(DELAY_MIN)) begin
              delay_q <= DELAY_W'(DELAY_MIN);
            end else if (cfg_data_i[DELAY_W-1:0] > DELAY_W'(DELAY_MAX)) begin
              delay_q <= DELAY_W'(DELAY_MAX);
            end else begin
              delay_q <= cfg_data_i[DELAY_W-1:0];
            end
          end
          CFG_FEEDBACK_PCT: begin
            fb_pct_q <= (cfg_data_i[PCT_W-1:0] > PCT_W'(PCT_MAX)) ?
                        PCT_W'(PCT_MAX) : cfg_data_i[PCT_W-1:0];
          end
          CFG_OUTPUT_PCT: begin
            out_pct_q <= (cfg_data_i[PCT_W-1:0] > PCT_W'(PCT_MAX)) ?
                         PCT_W'(PCT_MAX) : cfg_data_i[PCT_W-1:0];
          end
          CFG_SAMPLES_PER_MS: begin
            if (cfg_data_i[SPM_W-1:0] < SPM_W'(SPM_MIN)) begin
              spm_q <= SPM_W'(SPM_MIN);
            end else if (cfg_data_i[SPM_W-1:0] > SPM_W'(SPM_MAX)) begin
              spm_q <= SPM_W'(SPM_MAX);
            end else begin
              spm_q <= cfg_data_i[SPM_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      if (state_q == ST_CALC_FB) begin
        line_len_q <= len_calc;
      end
      if (state_q == ST_CALC_OG) begin
        fb_q <= mul_p[RECIP25_SHIFT +: GAIN_W];
      end
      if (state_q == ST_CALC_DONE) begin
        og_q <= mul_p[RECIP25_SHIFT +: GAIN_W];
      end

      // Advance the ring once the new sample has been written back.
      if (state_q == ST_MIX) begin
        if (pos_next >= line_len_q) begin
          pos_q[ch_q]     <= '0;
          wrapped_q[ch_q] <= 1'b1;
        end else begin
          pos_q[ch_q] <= pos_next[POS_W-1:0];
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the request in flight and of the output register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q      <= in_ch;
      live_q    <= in_sample;
      cur_pos_q <= pos_q[in_ch];
      hit_q     <= wrapped_q[in_ch];
    end
    if (out_load) begin
      out_ch_q     <= ch_q;
      out_sample_q <= prod_div[SAMPLE_W-1:0];
    end
  end

endmodule

>>> design/fdly_ram.sv
// Generic single-port RAM with registered read data.
module fdly_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/fdly_mul.sv
// Shared signed multiplier with a registered product.
module fdly_mul import fdly_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule
